// ===== hw/rtl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg: shared definitions for the FIFO queue with search
// Holds field widths, command and status codes, and the control structs that
// pass between the sequencer, the match unit and the top level.
// ----------------------------------------------------------------------------
package fqs_pkg;

	localparam int DATA_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_SRCH = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_DONE
	} state_t;

	// Control of the shared compare unit.
	typedef struct packed {
		logic load;   // latch a new key and clear the hit flag
		logic cmp;    // memory read data is valid, compare it
	} match_ctl_t;

	// Result handed to the output register.
	typedef struct packed {
		logic    load;
		status_t status;
		logic    sel_rdata;
		logic    found;
	} res_ctl_t;

endpackage

// ===== hw/rtl/fqs_if.sv =====
// ----------------------------------------------------------------------------
// fqs_if: request and response channels of the FIFO queue with search
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface fqs_req_if;
	logic                              valid;
	logic                              ready;
	logic [fqs_pkg::CMD_W-1:0]         command;
	logic signed [fqs_pkg::DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface fqs_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [fqs_pkg::STATUS_W-1:0]      status;
	logic signed [fqs_pkg::DATA_W-1:0] read_value;
	logic                              found;

	modport source (output valid, output status, output read_value, output found,
		input ready);
	modport sink   (input valid, input status, input read_value, input found,
		output ready);
endinterface

// ===== hw/rtl/fqs_ram.sv =====
// ----------------------------------------------------------------------------
// fqs_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/fqs_match.sv =====
// ----------------------------------------------------------------------------
// fqs_match: shared compare unit
// Holds the search key and accumulates a hit over the entries read out.
// ----------------------------------------------------------------------------
module fqs_match (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fqs_pkg::match_ctl_t       ctl,
	input  logic [fqs_pkg::DATA_W-1:0] key,
	input  logic [fqs_pkg::DATA_W-1:0] rdata,
	output logic                      hit
);

	logic [fqs_pkg::DATA_W-1:0] key_q;
	logic                       hit_q;
	logic                       eq;

	assign eq  = (rdata == key_q);
	assign hit = hit_q | (ctl.cmp & eq);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.load) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp) begin
			hit_q <= hit_q | eq;
		end
	end

endmodule

// ===== hw/rtl/fqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqs_ctrl: queue pointers and command sequencer
// Keeps head, tail and occupancy, drives the RAM ports, steps a search over
// the stored entries one per cycle and hands each result to the output stage.
// ----------------------------------------------------------------------------
module fqs_ctrl #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [fqs_pkg::CMD_W-1:0] in_cmd,
	output logic                      in_ready,
	input  logic                      out_free,
	input  logic                      hit,
	output logic                      we,
	output logic [$clog2(DEPTH)-1:0]  waddr,
	output logic                      re,
	output logic [$clog2(DEPTH)-1:0]  raddr,
	output fqs_pkg::match_ctl_t       mctl,
	output fqs_pkg::res_ctl_t         res
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

	fqs_pkg::state_t state_q, state_d;

	logic [AW-1:0] head_q, tail_q, rd_ptr_q;
	logic [OW-1:0] occ_q, left_q;
	fqs_pkg::status_t status_q;
	logic sel_q, found_q;

	logic acc, is_empty, is_full;
	logic [AW-1:0] head_nx, tail_nx, rd_ptr_nx;

	assign acc      = in_valid & in_ready;
	assign is_empty = (occ_q == '0);
	assign is_full  = (occ_q == FULL_OCC);
	assign head_nx   = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
	assign tail_nx   = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
	assign rd_ptr_nx = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fqs_pkg::S_IDLE: begin
				if (acc && !is_empty) begin
					if (in_cmd == fqs_pkg::CMD_DEQ) begin
						state_d = fqs_pkg::S_DONE;
					end else if (in_cmd == fqs_pkg::CMD_SRCH) begin
						state_d = (occ_q == OW'(1)) ? fqs_pkg::S_DONE : fqs_pkg::S_SRCH;
					end
				end
			end
			fqs_pkg::S_SRCH: begin
				if (left_q == '0) begin
					state_d = fqs_pkg::S_DONE;
				end
			end
			fqs_pkg::S_DONE: begin
				if (out_free) begin
					state_d = fqs_pkg::S_IDLE;
				end
			end
			default: state_d = fqs_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready       = 1'b0;
		we             = 1'b0;
		waddr          = tail_q;
		re             = 1'b0;
		raddr          = head_q;
		mctl           = '0;
		res.load       = 1'b0;
		res.status     = fqs_pkg::STS_OK;
		res.sel_rdata  = 1'b0;
		res.found      = 1'b0;
		unique case (state_q)
			fqs_pkg::S_IDLE: begin
				in_ready = out_free;
				if (acc) begin
					unique case (in_cmd)
						fqs_pkg::CMD_ENQ: begin
							res.load = 1'b1;
							if (is_full) begin
								res.status = fqs_pkg::STS_FULL;
							end else begin
								we = 1'b1;
							end
						end
						fqs_pkg::CMD_DEQ: begin
							if (is_empty) begin
								res.load   = 1'b1;
								res.status = fqs_pkg::STS_EMPTY;
							end else begin
								re = 1'b1;
							end
						end
						fqs_pkg::CMD_SRCH: begin
							if (is_empty) begin
								res.load = 1'b1;
							end else begin
								re        = 1'b1;
								mctl.load = 1'b1;
							end
						end
						default: res.load = 1'b1;
					endcase
				end
			end
			fqs_pkg::S_SRCH: begin
				// Every search cycle compares one entry and fetches the next;
				// the last entry fetched here is compared in S_DONE.
				mctl.cmp = 1'b1;
				raddr    = rd_ptr_q;
				re       = 1'b1;
			end
			fqs_pkg::S_DONE: begin
				res.load      = out_free;
				res.status    = status_q;
				res.sel_rdata = sel_q;
				// The hit flag keeps the outcome of an earlier search, so only
				// a search reports it.
				res.found     = ~sel_q & (found_q | hit);
				mctl.cmp      = ~sel_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fqs_pkg::S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			rd_ptr_q <= '0;
			left_q   <= '0;
			status_q <= fqs_pkg::STS_OK;
			sel_q    <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fqs_pkg::S_IDLE && acc) begin
				found_q  <= 1'b0;
				status_q <= fqs_pkg::STS_OK;
				if (in_cmd == fqs_pkg::CMD_ENQ && !is_full) begin
					tail_q <= tail_nx;
					occ_q  <= occ_q + OW'(1);
				end
				if (in_cmd == fqs_pkg::CMD_DEQ && !is_empty) begin
					head_q <= head_nx;
					occ_q  <= occ_q - OW'(1);
					sel_q  <= 1'b1;
				end
				if (in_cmd == fqs_pkg::CMD_SRCH && !is_empty) begin
					rd_ptr_q <= head_nx;
					left_q   <= occ_q - OW'(2);
					sel_q    <= 1'b0;
				end
			end
			if (state_q == fqs_pkg::S_SRCH) begin
				if (left_q != '0) begin
					rd_ptr_q <= rd_ptr_nx;
					left_q   <= left_q - OW'(1);
				end else begin
					found_q <= hit;
				end
			end
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("occupancy above capacity");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty |-> head_q == tail_q)
		else $error("empty queue with head and tail apart");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		is_full |-> head_q == tail_q)
		else $error("full queue with head and tail apart");

	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re))
		else $error("write and read issued together");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fqs_pkg::S_SRCH |-> left_q < occ_q)
		else $error("search count beyond occupancy");

endmodule

// ===== hw/rtl/fifo_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search: bounded FIFO of 32-bit words with content search
// Top level: request/response channels, storage RAM, sequencer, compare unit
// and the response register.
// ----------------------------------------------------------------------------
// Each request beat carries a command (enqueue, dequeue or search) and a word,
// and yields exactly one response beat with status, read_value and found.
// Enqueue, a dequeue or search of an empty queue and the unused command code
// reach the response register at the edge that accepts them. A successful
// dequeue passes through the done state first, because the word comes out
// of the registered single read port of the storage RAM. A search reads the
// stored entries one per cycle through that same port and compares each
// with the key in one shared comparator. One request is in work at a time;
// a new request is taken as soon as the sequencer is idle and the response
// register is empty or being emptied in the same cycle. The storage is not
// cleared at reset and needs no clearing pass: only entries that were
// written are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_search #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	fqs_req_if.sink       req,
	fqs_rsp_if.source     rsp
);

	localparam int AW = $clog2(DEPTH);

	// Storage port signals from the sequencer.
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [fqs_pkg::DATA_W-1:0] rdata;

	fqs_pkg::match_ctl_t mctl;
	fqs_pkg::res_ctl_t   res;
	logic                hit;

	// Response register state.
	logic                         out_valid_q;
	logic [fqs_pkg::STATUS_W-1:0] status_q;
	logic [fqs_pkg::DATA_W-1:0]   read_value_q;
	logic                         found_q;
	logic                         out_free;

	// The response register can take a new result when it is empty or when
	// its current beat leaves at this edge.
	assign out_free = ~out_valid_q | rsp.ready;

	fqs_ram #(
		.WIDTH (fqs_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req.value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	fqs_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.command),
		.in_ready (req.ready),
		.out_free (out_free),
		.hit      (hit),
		.we       (we),
		.waddr    (waddr),
		.re       (re),
		.raddr    (raddr),
		.mctl     (mctl),
		.res      (res)
	);

	// The key is latched from the request beat when a search starts.
	fqs_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.key    (req.value),
		.rdata  (rdata),
		.hit    (hit)
	);

	// Response valid flag. A new result only loads when out_free is high, so
	// a waiting beat is never overwritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload. The dequeued word is still held in the RAM read
	// register when the sequencer hands the result over.
	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q     <= res.status;
			read_value_q <= res.sel_rdata ? rdata : '0;
			found_q      <= res.found;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = read_value_q;
	assign rsp.found      = found_q;

endmodule

// ===== test/tb_fifo_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_search: self-checking bench for the searchable FIFO queue
// A short table of directed requests is followed by random request streams
// that fill, overflow, drain and search the queue. Every response beat is
// compared with the next owed result, typed in the plan or from the shadow queue.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_search;

	timeunit 1ns;
	timeprecision 1ps;

	import fqs_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	// The command field is two bits wide, so one code is left unused.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// One response as the queue should deliver it.
	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  read_value;
		logic                      found;
	} outcome_t;

	// A row of the directed plan. A row is issued reps times, with the word
	// stepping up by one each time. Where known_good is set, the response is
	// typed into the row; elsewhere it comes from the shadow queue.
	typedef struct {
		logic [CMD_W-1:0]          cmd;
		logic signed [DATA_W-1:0]  word;
		int                        reps;
		bit                        known_good;
		outcome_t                  want;
	} plan_row_t;

	localparam int PLAN_ROWS = 14;

	plan_row_t plan [PLAN_ROWS] = '{
		// Fresh out of reset: nothing to dequeue, nothing to find.
		'{CMD_DEQ,    32'sh0000_0000, 1, 1'b1, '{STS_EMPTY, 32'sh0, 1'b0}},
		'{CMD_SRCH,   32'sh0000_0000, 1, 1'b1, '{STS_OK,    32'sh0, 1'b0}},
		// The unused code must leave the queue alone.
		'{CMD_UNUSED, 32'sh5a5a_5a5a, 1, 1'b1, '{STS_OK,    32'sh0, 1'b0}},
		// Largest and smallest words.
		'{CMD_ENQ,    32'sh7fff_ffff, 1, 1'b1, '{STS_OK,    32'sh0, 1'b0}},
		'{CMD_ENQ,    32'sh8000_0000, 1, 1'b1, '{STS_OK,    32'sh0, 1'b0}},
		'{CMD_SRCH,   32'sh8000_0000, 1, 1'b0, '{STS_OK,    32'sh0, 1'b0}},
		'{CMD_SRCH,   32'sh0000_0000, 1, 1'b0, '{STS_OK,    32'sh0, 1'b0}},
		'{CMD_DEQ,    32'shffff_ffff, 1, 1'b1, '{STS_OK,    32'sh7fff_ffff, 1'b0}},
		'{CMD_DEQ,    32'shffff_ffff, 1, 1'b1, '{STS_OK,    32'sh8000_0000, 1'b0}},
		// The queue has just been emptied and must now read as empty.
		'{CMD_DEQ,    32'sh0000_0000, 1, 1'b1, '{STS_EMPTY, 32'sh0, 1'b0}},
		// Refill to the brim; head sits at two, so the tail wraps on the way.
		'{CMD_ENQ,    32'sh0000_0100, DEPTH, 1'b0, '{STS_OK, 32'sh0, 1'b0}},
		'{CMD_ENQ,    32'shffff_ffff, 1, 1'b1, '{STS_FULL,  32'sh0, 1'b0}},
		// Last word stored is found, the one just dropped is not.
		'{CMD_SRCH,   32'sh0000_010f, 1, 1'b0, '{STS_OK,    32'sh0, 1'b0}},
		'{CMD_SRCH,   32'shffff_ffff, 1, 1'b0, '{STS_OK,    32'sh0, 1'b0}}
	};

	logic clk;
	logic arst_n;

	fqs_req_if req_ch ();
	fqs_rsp_if rsp_ch ();

	fifo_queue_with_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the queue contents and pointers.
	logic signed [DATA_W-1:0] shadow_slots [DEPTH];
	int unsigned              shadow_head;
	int unsigned              shadow_tail;
	int unsigned              shadow_fill;

	// Responses still owed by the block, oldest first.
	outcome_t awaited_rsp [$];

	int  accepted_beats = 0;
	int  mismatches = 0;
	int  cycles = 0;
	// While calm is set neither side inserts idle cycles.
	bit  calm = 1'b0;

	// Applies one accepted request to the shadow queue and returns the
	// response that the block owes for it.
	function automatic outcome_t fifo_outcome(input logic [CMD_W-1:0] cmd,
		input logic signed [DATA_W-1:0] word);
		outcome_t    res;
		int unsigned pos;
		res = '{status: STS_OK, read_value: '0, found: 1'b0};
		case (cmd)
			CMD_ENQ: begin
				if (shadow_fill == DEPTH) begin
					res.status = STS_FULL;
				end else begin
					shadow_slots[shadow_tail] = word;
					shadow_tail = (shadow_tail + 1) % DEPTH;
					shadow_fill++;
				end
			end
			CMD_DEQ: begin
				if (shadow_fill == 0) begin
					res.status = STS_EMPTY;
				end else begin
					res.read_value = shadow_slots[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
				end
			end
			CMD_SRCH: begin
				pos = shadow_head;
				for (int k = 0; k < shadow_fill; k++) begin
					if (shadow_slots[pos] == word) begin
						res.found = 1'b1;
					end
					pos = (pos + 1) % DEPTH;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// A word drawn so that extremes and repeated small values turn up often;
	// repeats make searches hit more than one stored copy.
	function automatic logic signed [DATA_W-1:0] pick_word();
		logic signed [DATA_W-1:0] w;
		case ($urandom_range(7))
			0: w = 32'sh7fff_ffff;
			1: w = 32'sh8000_0000;
			2: w = $signed(DATA_W'($urandom_range(7))) - 32'sd4;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// Offers one request beat and waits until the block takes it. The valid
	// line is left high at the acceptance edge; the next call either keeps it
	// high with a new beat or drops it for an idle gap, one assignment each.
	task automatic offer(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] word,
		input bit known_good, input outcome_t want);
		outcome_t predicted;
		if (!calm) begin
			while ($urandom_range(99) < 19) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value <= word;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		// The shadow queue always moves, so that it stays in step with the
		// block; typed rows then hold the block to the value written down.
		predicted = fifo_outcome(cmd, word);
		awaited_rsp.push_back(known_good ? want : predicted);
		accepted_beats++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that hangs anywhere ends here.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_fifo_queue_with_search NOT OK");
		$finish;
	end

	// Request side: reset, the directed plan, then random traffic.
	initial begin : req_side
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] word;
		bit                       filling;
		int unsigned              roll;
		outcome_t                 none;

		none = '{status: STS_OK, read_value: '0, found: 1'b0};
		filling = 1'b1;
		shadow_head = 0;
		shadow_tail = 0;
		shadow_fill = 0;

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_ENQ;
		req_ch.value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			for (int i = 0; i < plan[r].reps; i++) begin
				offer(plan[r].cmd, plan[r].word + i, plan[r].known_good, plan[r].want);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Once in the run the sender stops and lets the block run dry.
			if (n == 700) begin
				req_ch.valid <= 1'b0;
				while (awaited_rsp.size() != 0) begin
					@(posedge clk);
				end
			end
			// A long stretch in which neither side ever idles.
			calm = (n >= 900 && n < 1150);

			// Streams lean toward filling until the queue is full, then
			// toward draining until it is empty, with the odd early turn.
			if (shadow_fill == DEPTH) begin
				filling = 1'b0;
			end else if (shadow_fill == 0) begin
				filling = 1'b1;
			end else if ($urandom_range(63) == 0) begin
				filling = !filling;
			end

			roll = $urandom_range(99);
			word = $urandom;
			if (roll < 4) begin
				cmd = CMD_UNUSED;
			end else if (roll < 28) begin
				cmd = CMD_SRCH;
				// Half of the keys are copies of a word now stored.
				if (shadow_fill != 0 && $urandom_range(1) == 1) begin
					word = shadow_slots[(shadow_head + $urandom_range(shadow_fill - 1)) % DEPTH];
				end else begin
					word = pick_word();
				end
			end else if ($urandom_range(99) < (filling ? 75 : 25)) begin
				cmd = CMD_ENQ;
				word = pick_word();
			end else begin
				cmd = CMD_DEQ;
			end
			offer(cmd, word, 1'b0, none);
		end
		req_ch.valid <= 1'b0;

		while (awaited_rsp.size() != 0) begin
			@(posedge clk);
		end
		// Give stray beats time to show up.
		repeat (4 * DEPTH) @(posedge clk);
		mismatches += awaited_rsp.size();

		if (mismatches == 0) begin
			$display("tb_fifo_queue_with_search OK");
		end else begin
			$display("tb_fifo_queue_with_search NOT OK");
		end
		$finish;
	end

	// Response side: checks every beat and throttles ready. At one point the
	// receiver refuses beats for a long stretch so that the block backs up
	// and holds off new requests.
	initial begin : rsp_side
		outcome_t want;
		int       hold_left;
		bit       held;

		hold_left = 0;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_rsp.size() == 0) begin
					if (mismatches < MAX_REPORTS) begin
						$display("unexpected response beat: status %0d read_value %0d found %0d",
							rsp_ch.status, rsp_ch.read_value, rsp_ch.found);
					end
					mismatches++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value
						|| rsp_ch.found !== want.found) begin
						if (mismatches < MAX_REPORTS) begin
							$display("response mismatch: expected status %0d read_value %0d found %0d, got status %0d read_value %0d found %0d",
								want.status, want.read_value, want.found,
								rsp_ch.status, rsp_ch.read_value, rsp_ch.found);
						end
						mismatches++;
					end
				end
			end

			if (!held && accepted_beats >= 300) begin
				held = 1'b1;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 19);
			end
		end
	end

endmodule

// ===== fifo_queue_with_search.f =====
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_if.sv
hw/rtl/fqs_ram.sv
hw/rtl/fqs_match.sv
hw/rtl/fqs_ctrl.sv
hw/rtl/fifo_queue_with_search.sv
test/tb_fifo_queue_with_search.sv
